### design/fqs_pkg.sv
package fqs_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PUSH     = 3'd0,
    OP_POP      = 3'd1,
    OP_MOVE     = 3'd2,
    OP_CONTAINS = 3'd3,
    OP_CLEAR    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]        operation;
    logic [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic              head_valid;
    logic [DATA_W-1:0] head_value;
    logic [CNT_W-1:0]  entry_count;
    logic              found;
    logic [1:0]        status;
  } out_item_t;

  // one write and one read request to the entry store
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

  // circular slot index: base + off, wrapped once at DEPTH
  function automatic logic [IDX_W-1:0] slot_after(logic [IDX_W-1:0] base,
                                                  logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

### design/fqs_ram.sv
module fqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/fqs_ctrl.sv
module fqs_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  fqs_pkg::in_item_t        in_data,
  output fqs_pkg::ram_req_t        ram_req,
  input  logic [fqs_pkg::DATA_W-1:0] ram_rdata,
  input  logic                     slot_free,
  output logic                     res_valid,
  output fqs_pkg::out_item_t       res
);
  import fqs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE_RD,
    S_MOVE_WR,
    S_SEARCH,
    S_HEAD_RD,
    S_HEAD_WAIT,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic [DATA_W-1:0] word_r, word_nxt;
  logic              found_r, found_nxt;
  status_t           status_r, status_nxt;
  logic [DATA_W-1:0] head_val_r, head_val_nxt;

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    pend_nxt     = pend_r;
    word_nxt     = word_r;
    found_nxt    = found_r;
    status_nxt   = status_r;
    head_val_nxt = head_val_r;
    ram_req      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          found_nxt  = 1'b0;
          status_nxt = ST_DONE;
          state_nxt  = S_HEAD_RD;
          case (op_t'(in_data.operation))
            OP_PUSH: begin
              if (count_r == CNT_W'(DEPTH)) begin
                status_nxt = ST_PUSH_FULL;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = slot_after(head_r, count_r);
                ram_req.wdata = in_data.value;
                count_nxt     = count_r + CNT_W'(1);
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                status_nxt = ST_POP_EMPTY;
              end else begin
                head_nxt  = slot_after(head_r, CNT_W'(1));
                count_nxt = count_r - CNT_W'(1);
              end
            end
            OP_MOVE: begin
              if (count_r >= CNT_W'(2)) begin
                state_nxt = S_MOVE_RD;
              end
            end
            OP_CONTAINS: begin
              word_nxt  = in_data.value;
              idx_nxt   = '0;
              pend_nxt  = 1'b0;
              state_nxt = S_SEARCH;
            end
            OP_CLEAR: begin
              head_nxt  = '0;
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_MOVE_RD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = head_r;
        state_nxt     = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = slot_after(head_r, count_r);
        ram_req.wdata = ram_rdata;
        head_nxt      = slot_after(head_r, CNT_W'(1));
        state_nxt     = S_HEAD_RD;
      end
      S_SEARCH: begin
        if (pend_r && (ram_rdata == word_r)) begin
          found_nxt = 1'b1;
        end
        if (idx_r < count_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = slot_after(head_r, idx_r);
          idx_nxt       = idx_r + CNT_W'(1);
          pend_nxt      = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_HEAD_RD;
          end
        end
      end
      S_HEAD_RD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = head_r;
        state_nxt     = S_HEAD_WAIT;
      end
      S_HEAD_WAIT: begin
        head_val_nxt = (count_r != '0) ? ram_rdata : '0;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_r     <= '0;
      count_r    <= '0;
      idx_r      <= '0;
      pend_r     <= 1'b0;
      word_r     <= '0;
      found_r    <= 1'b0;
      status_r   <= ST_DONE;
      head_val_r <= '0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      count_r    <= count_nxt;
      idx_r      <= idx_nxt;
      pend_r     <= pend_nxt;
      word_r     <= word_nxt;
      found_r    <= found_nxt;
      status_r   <= status_nxt;
      head_val_r <= head_val_nxt;
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign res_valid       = (state_r == S_DONE);
  assign res.head_valid  = (count_r != '0);
  assign res.head_value  = head_val_r;
  assign res.entry_count = count_r;
  assign res.found       = found_r;
  assign res.status      = status_r;

endmodule

### design/fifo_queue_with_search.sv
// fifo queue with search: one item in flight at a time, one result beat per item
// push, pop, clear, unused codes and a move on fewer than two entries pass the head read,
// head wait and done states before the result beat loads; a move that rotates first reads the
// head and writes it at the rear; contains first scans the stored entries, one read per cycle
// next input beat is taken the cycle after the result loads; a stalled result beat delays it
// reset (rst_n low, synchronous) empties the queue; stored words stay undefined until pushed
module fifo_queue_with_search (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fqs_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fqs_pkg::out_item_t  out_data
);
  import fqs_pkg::*;

  // control to store request, and read data back
  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;

  // finished result from the controller
  logic              res_valid;
  out_item_t         res;
  logic              slot_free;

  logic              out_valid_r;
  out_item_t         out_data_r;

  // output register is free when empty or being drained this cycle
  assign slot_free = !out_valid_r || out_ready;

  fqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .slot_free (slot_free),
    .res_valid (res_valid),
    .res       (res)
  );

  // entry store: single write, single registered read
  // the controller never reads a slot in the cycle it writes it, so no bypass
  fqs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // result beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && slot_free) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // count never exceeds the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.entry_count <= CNT_W'(DEPTH)))
    else $error("entry count above depth");

  // head flag tracks a non-empty queue
  a_head_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.head_valid == (out_data.entry_count != '0)))
    else $error("head flag disagrees with count");

  // an ignored pop only happens on an empty queue
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_POP_EMPTY)) |-> (out_data.entry_count == '0))
    else $error("pop flagged empty on non-empty queue");

  // one item at a time: input closes right after a beat is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while busy");
`endif

endmodule

### bench/queue_result_checker.sv
module queue_result_checker
  import fqs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        mismatches,
  output int        results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the queue
  logic [DATA_W-1:0] held_words [DEPTH];
  logic [IDX_W-1:0]  head_slot;
  logic [CNT_W-1:0]  held_count;

  out_item_t predicted_views[$];
  int        beats_checked;

  initial begin
    mismatches    = 0;
    results_owed  = 0;
    beats_checked = 0;
    head_slot     = '0;
    held_count    = '0;
  end

  task automatic log_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // applies one request to the shadow queue and returns the view after it
  function automatic out_item_t next_queue_view(input in_item_t req);
    out_item_t view;
    int        rear;
    view        = '0;
    view.status = ST_DONE;
    rear        = (int'(head_slot) + int'(held_count)) % DEPTH;
    case (req.operation)
      OP_PUSH: begin
        if (held_count == CNT_W'(DEPTH)) begin
          view.status = ST_PUSH_FULL;
        end else begin
          held_words[rear] = req.value;
          held_count++;
        end
      end
      OP_POP: begin
        if (held_count == '0) begin
          view.status = ST_POP_EMPTY;
        end else begin
          head_slot = IDX_W'((int'(head_slot) + 1) % DEPTH);
          held_count--;
        end
      end
      OP_MOVE: begin
        if (held_count >= CNT_W'(2)) begin
          held_words[rear] = held_words[head_slot];
          head_slot        = IDX_W'((int'(head_slot) + 1) % DEPTH);
        end
      end
      OP_CONTAINS: begin
        for (int i = 0; i < int'(held_count); i++) begin
          if (held_words[(int'(head_slot) + i) % DEPTH] == req.value) begin
            view.found = 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        held_count = '0;
        head_slot  = '0;
      end
      default: begin
      end
    endcase
    view.head_valid  = (held_count != '0);
    view.head_value  = (held_count != '0) ? held_words[head_slot] : '0;
    view.entry_count = held_count;
    return view;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      head_slot  = '0;
      held_count = '0;
      predicted_views.delete();
    end else begin
      if (in_valid && in_ready) begin
        predicted_views.push_back(next_queue_view(in_data));
      end
      if (out_valid && out_ready) begin
        if (predicted_views.size() == 0) begin
          log_error($sformatf("result beat %0d arrived with nothing expected", beats_checked));
        end else begin
          want = predicted_views.pop_front();
          if (out_data.head_valid !== want.head_valid) begin
            log_error($sformatf("beat %0d head_valid: got %b, expected %b",
                                beats_checked, out_data.head_valid, want.head_valid));
          end
          if (out_data.head_value !== want.head_value) begin
            log_error($sformatf("beat %0d head_value: got %h, expected %h",
                                beats_checked, out_data.head_value, want.head_value));
          end
          if (out_data.entry_count !== want.entry_count) begin
            log_error($sformatf("beat %0d entry_count: got %0d, expected %0d",
                                beats_checked, out_data.entry_count, want.entry_count));
          end
          if (out_data.found !== want.found) begin
            log_error($sformatf("beat %0d found: got %b, expected %b",
                                beats_checked, out_data.found, want.found));
          end
          if (out_data.status !== want.status) begin
            log_error($sformatf("beat %0d status: got %0d, expected %0d",
                                beats_checked, out_data.status, want.status));
          end
        end
        beats_checked++;
      end
    end
    results_owed = predicted_views.size();
  end

endmodule

### bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fqs_pkg::*;

  // unused operation codes, expected to change nothing
  localparam logic [2:0] FIRST_UNUSED_OP = 3'd5;
  localparam logic [2:0] LAST_UNUSED_OP  = 3'd7;

  localparam int RESET_CYCLES  = 11;
  localparam int RANDOM_ITEMS  = 600;
  localparam int HOLD_AFTER    = 250;   // result beats drained before the long hold-off
  localparam int HOLD_CYCLES   = 300;   // length of the long hold-off
  localparam int QUIET_LIMIT   = 2000;  // cycles without any beat before giving up
  localparam int SETTLE_CYCLES = 40;    // longer than a search over a full queue

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int mismatches;
  int results_owed;

  // words pushed lately, so that searches hit now and then
  logic [DATA_W-1:0] recent_words [16];
  int                recent_wr;
  // no sender gaps while set
  bit                steady_sender;

  always #5 clk = ~clk;

  fifo_queue_with_search DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  queue_result_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  // mostly short gaps, some medium, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      return $urandom_range(1, 3);
    end else if (roll < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // offers one request beat and returns at the edge where it is taken
  task automatic offer_request(input logic [2:0] op_code, input logic [DATA_W-1:0] word);
    in_item_t beat;
    int       gap;
    beat.operation = op_code;
    beat.value     = word;
    gap = (steady_sender || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    // valid drops only when a gap follows, so it is never lowered and raised in one step
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    if (op_code == OP_PUSH) begin
      recent_words[recent_wr] = word;
      recent_wr = (recent_wr + 1) % 16;
    end
  endtask

  // result side: random stalls, calm stretches and one long hold-off
  initial begin : result_sink
    int drained;
    int stall_left;
    int cyc;
    bit held_once;
    drained    = 0;
    stall_left = 0;
    cyc        = 0;
    held_once  = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (out_valid && out_ready) begin
        drained++;
      end
      if (!held_once && drained == HOLD_AFTER) begin
        // block holds its result, input side keeps offering and gets stalled
        held_once = 1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        // in one time window out of every four the sink starts no new stall
        if (stall_left == 0 && (cyc / 128) % 4 != 2 && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
        out_ready <= (stall_left == 0);
        if (stall_left > 0) begin
          stall_left--;
        end
      end
    end
  end

  // ends the run when no beat moves on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : request_source
    logic [2:0]        op_code;
    logic [DATA_W-1:0] word;
    int                fill_pct;
    int                roll;
    recent_wr     = 0;
    steady_sender = 0;
    fill_pct      = 50;
    for (int k = 0; k < 16; k++) begin
      recent_words[k] = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-queue cases first
    offer_request(OP_POP, '0);
    offer_request(OP_CONTAINS, '0);
    offer_request(OP_MOVE, '0);
    offer_request(OP_PUSH, '1);
    // move with a single entry changes nothing
    offer_request(OP_MOVE, '1);
    for (int u = FIRST_UNUSED_OP; u <= LAST_UNUSED_OP; u++) begin
      offer_request(3'(u), $urandom);
    end
    // fill to capacity, the last word repeats the first
    for (int k = 1; k < DEPTH; k++) begin
      if (k == 1) begin
        word = '0;
      end else if (k == 2) begin
        word = {1'b1, {(DATA_W - 1){1'b0}}};
      end else begin
        word = DATA_W'(k) * 32'h1111_1111;
      end
      offer_request(OP_PUSH, word);
    end
    offer_request(OP_PUSH, 32'h1234_5678);   // dropped on full
    offer_request(OP_MOVE, '0);              // head slot turns into rear slot
    offer_request(OP_CONTAINS, 32'h3333_3333);
    offer_request(OP_CONTAINS, 32'h1234_5678);
    offer_request(OP_CLEAR, '0);

    // random: phases lean toward filling, draining or neither
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       fill_pct = 85;
          1:       fill_pct = 50;
          default: fill_pct = 20;
        endcase
      end
      steady_sender = ((n / 64) % 3 == 1);
      roll = $urandom_range(0, 99);
      if (roll < 1) begin
        op_code = OP_CLEAR;
      end else if (roll < 3) begin
        op_code = 3'($urandom_range(FIRST_UNUSED_OP, LAST_UNUSED_OP));
      end else if (roll < 63) begin
        op_code = ($urandom_range(0, 99) < fill_pct) ? OP_PUSH : OP_POP;
      end else if (roll < 79) begin
        op_code = OP_MOVE;
      end else begin
        op_code = OP_CONTAINS;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: word = $urandom;
        6, 7:             word = DATA_W'($urandom_range(0, 7));
        8:                word = $urandom_range(0, 1) ? '1 : {1'b1, {(DATA_W - 1){1'b0}}};
        default:          word = recent_words[$urandom_range(0, 15)];
      endcase
      // searches look for a recently pushed word about half the time
      if (op_code == OP_CONTAINS && $urandom_range(0, 1) == 1) begin
        word = recent_words[$urandom_range(0, 15)];
      end
      offer_request(op_code, word);
    end
    in_valid <= 1'b0;

    // drain: let the checker catch up on the last beat, then wait it out
    @(posedge clk);
    wait (results_owed == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
